>>> sv/sid_pkg.sv
package sid_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } sid_state_type;

   // Control from the sequencer to the shift/subtract unit
   typedef struct packed {
      logic load;
      logic step;
   } sid_ctrl_type;

endpackage

>>> sv/sid_divcore.sv
module sid_divcore #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sid_pkg::sid_ctrl_type       ctrl,
   input  logic [DATA_WIDTH-1:0]       dividend_mag,
   input  logic [DATA_WIDTH-1:0]       divisor_mag,
   output logic [DATA_WIDTH-1:0]       quotient_mag,
   output logic                        last
);
   import sid_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] quo_ff;
   logic [DATA_WIDTH-1:0] dvs_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [DATA_WIDTH-1:0] rem_shift;
   logic [DATA_WIDTH:0]   diff;

   // Remainder stays below the divisor, so its top bit is free for the shift
   assign rem_shift = {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rem_ff <= '0;
         quo_ff <= dividend_mag;
         dvs_ff <= divisor_mag;
      end else if (ctrl.step) begin
         // Shift one dividend bit into the remainder, one quotient bit out
         rem_ff <= diff[DATA_WIDTH] ? rem_shift : diff[DATA_WIDTH-1:0];
         quo_ff <= {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.load) begin
         cnt_ff <= CNT_W'(DATA_WIDTH - 1);
      end else if (ctrl.step && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign quotient_mag = quo_ff;
   assign last         = (cnt_ff == '0);

endmodule

>>> sv/signed_integer_divider.sv
// Signed integer divider, quotient truncated toward zero.
//
// Request channel: req_numerator and req_denominator transfer when req_valid
// is high and req_stall is low. Response channel: rsp_quotient and
// rsp_div_by_zero transfer when rsp_valid is high and rsp_stall is low.
//
// One item is in work at a time. The request transfer edge loads the operand
// magnitudes into a restoring shift/subtract unit, which then produces one
// quotient bit per cycle until all DATA_WIDTH bits are done; a sign fix-up
// state follows and loads the result into the output register. req_stall
// drops in the cycle the result first shows on rsp_valid, and a new request
// can transfer while the previous result still waits.
//
// A zero divisor gives quotient zero with rsp_div_by_zero set. The most
// negative dividend over minus one saturates to the largest positive value.
// If the receiver stalls, the result holds in the output register and the
// fix-up stage waits until that register frees up.
// Synchronous reset returns to idle with no response pending.
module signed_integer_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_numerator,
   input  logic signed [DATA_WIDTH-1:0]  req_denominator,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_quotient,
   output logic                          rsp_div_by_zero
);
   import sid_pkg::*;

   sid_state_type state_ff, state_in;
   sid_ctrl_type  ctrl;

   logic req_xfer;
   logic out_free;
   logic out_load;
   logic last;

   logic [DATA_WIDTH-1:0] num_mag;
   logic [DATA_WIDTH-1:0] den_mag;
   logic [DATA_WIDTH-1:0] quo_mag;
   logic [DATA_WIDTH-1:0] result;

   logic                  neg_ff;
   logic                  dz_ff;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] quo_out_ff;
   logic                  dz_out_ff;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Magnitudes; the most negative value maps to 2**(DATA_WIDTH-1) unsigned
   assign num_mag = req_numerator[DATA_WIDTH-1]   ? -req_numerator   : req_numerator;
   assign den_mag = req_denominator[DATA_WIDTH-1] ? -req_denominator : req_denominator;

   sid_divcore #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_divcore (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .dividend_mag (num_mag),
      .divisor_mag  (den_mag),
      .quotient_mag (quo_mag),
      .last         (last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            if (last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // Hold here until the output register can take the result
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capture sign and zero-divisor flag with the operands
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         neg_ff <= req_numerator[DATA_WIDTH-1] ^ req_denominator[DATA_WIDTH-1];
         dz_ff  <= (req_denominator == '0);
      end
   end

   // Sign fix-up: negate, saturate the lone positive overflow, or force zero
   always_comb begin
      if (dz_ff) begin
         result = '0;
      end else if (neg_ff) begin
         result = -quo_mag;
      end else if (quo_mag[DATA_WIDTH-1]) begin
         result = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
         result = quo_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         quo_out_ff <= result;
         dz_out_ff  <= dz_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quotient    = quo_out_ff;
   assign rsp_div_by_zero = dz_out_ff;

endmodule

>>> sv/sid_checker.sv
module sid_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [DATA_WIDTH-1:0]  rsp_quotient,
   input logic                          rsp_div_by_zero
);

   // Busy right after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a division is in work");

   // A new result appears only as the block returns to idle
   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result posted while still busy");

   // Zero divisor forces a zero quotient
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_quotient == '0)
      else $error("nonzero quotient with divide-by-zero flag");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quotient)
                                 && $stable(rsp_div_by_zero))
      else $error("stalled result changed");

endmodule

bind signed_integer_divider sid_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_sid_checker (.*);
